>>> design/mswdb_pkg.sv
// ----------------------------------------------------------------------------
// mswdb_pkg
// Shared constants and types for the multi-switch debounce event block.
// ----------------------------------------------------------------------------
package mswdb_pkg;

    localparam int NUM_SWITCHES_DEFAULT = 3;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 8;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd1;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MIN   = 8'd1;

    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_PRESSED  = 2'd1;
    localparam logic [1:0] PHASE_RELEASED = 2'd2;

    typedef struct packed {
        logic press_event;
        logic release_event;
        logic pressed_now;
        logic debounced_closed;
    } lane_result_t;

endpackage

>>> design/mswdb_if.sv
// ----------------------------------------------------------------------------
// mswdb_scan_if / mswdb_event_if
// Valid/ready channels carrying scan words in and event words out.
// ----------------------------------------------------------------------------
interface mswdb_scan_if #(
    parameter int NUM_SWITCHES = mswdb_pkg::NUM_SWITCHES_DEFAULT
);
    logic                            valid;
    logic                            ready;
    logic [mswdb_pkg::TIME_W-1:0]    now_time;
    logic [NUM_SWITCHES-1:0]         raw_lines;

    modport source (output valid, output now_time, output raw_lines, input ready);
    modport sink   (input valid, input now_time, input raw_lines, output ready);
endinterface

interface mswdb_event_if #(
    parameter int NUM_SWITCHES = mswdb_pkg::NUM_SWITCHES_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic [NUM_SWITCHES-1:0] press_events;
    logic [NUM_SWITCHES-1:0] release_events;
    logic [NUM_SWITCHES-1:0] pressed_now;
    logic [NUM_SWITCHES-1:0] debounced_closed;

    modport source (
        output valid, output press_events, output release_events,
        output pressed_now, output debounced_closed, input ready
    );
    modport sink (
        input valid, input press_events, input release_events,
        input pressed_now, input debounced_closed, output ready
    );
endinterface

>>> design/mswdb_lane.sv
// ----------------------------------------------------------------------------
// mswdb_lane
// Debounce window and press/release state machine for one switch.
// ----------------------------------------------------------------------------
module mswdb_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [mswdb_pkg::TIME_W-1:0]        now_time,
    input  logic                                raw_line,
    input  logic [mswdb_pkg::DEBOUNCE_W-1:0]    debounce_time,
    output mswdb_pkg::lane_result_t             result
);

    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic                               closed_reg;
    logic                               closed_next;
    logic                               active_reg;
    logic                               active_next;
    logic [mswdb_pkg::TIME_W-1:0]       start_reg;
    logic [mswdb_pkg::TIME_W-1:0]       start_next;
    logic [mswdb_pkg::TIME_W-1:0]       diff;
    logic [mswdb_pkg::TIME_W-1:0]       magnitude;
    logic                               reached;
    logic                               raw_closed;
    logic                               press_event;
    logic                               release_event;

    assign raw_closed = ~raw_line;
    assign diff       = now_time - start_reg;
    assign magnitude  = diff[mswdb_pkg::TIME_W-1] ? (~diff + 32'd1) : diff;
    assign reached    = magnitude >= {{(mswdb_pkg::TIME_W-mswdb_pkg::DEBOUNCE_W){1'b0}},
                                      debounce_time};

    always_comb
    begin
        closed_next = closed_reg;
        active_next = active_reg;
        start_next  = start_reg;
        if (raw_closed != closed_reg)
        begin
            if (active_reg)
            begin
                if (reached)
                begin
                    closed_next = ~closed_reg;
                    active_next = 1'b0;
                end
            end
            else
            begin
                start_next  = now_time;
                active_next = 1'b1;
            end
        end
        else
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        press_event   = 1'b0;
        release_event = 1'b0;
        unique case (phase_reg)
            mswdb_pkg::PHASE_IDLE:
            begin
                if (closed_next)
                begin
                    phase_next  = mswdb_pkg::PHASE_PRESSED;
                    press_event = 1'b1;
                end
            end
            mswdb_pkg::PHASE_PRESSED:
            begin
                if (!closed_next)
                begin
                    phase_next    = mswdb_pkg::PHASE_RELEASED;
                    release_event = 1'b1;
                end
            end
            default:
            begin
                phase_next = mswdb_pkg::PHASE_IDLE;
            end
        endcase
    end

    assign result.press_event      = press_event;
    assign result.release_event    = release_event;
    assign result.pressed_now      = (phase_next == mswdb_pkg::PHASE_PRESSED);
    assign result.debounced_closed = closed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mswdb_pkg::PHASE_IDLE;
            closed_reg <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            closed_reg <= closed_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= start_next;
        end
    end

endmodule

>>> design/mswdb_merge.sv
// ----------------------------------------------------------------------------
// mswdb_merge
// Packs the lane results into one event word and holds it in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module mswdb_merge #(
    parameter int NUM_SWITCHES = mswdb_pkg::NUM_SWITCHES_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  mswdb_pkg::lane_result_t results [NUM_SWITCHES],
    mswdb_event_if.source           out_ch
);

    logic                    valid_reg;
    logic                    accept;
    logic [NUM_SWITCHES-1:0] press_next;
    logic [NUM_SWITCHES-1:0] release_next;
    logic [NUM_SWITCHES-1:0] pressed_next;
    logic [NUM_SWITCHES-1:0] closed_next;
    logic [NUM_SWITCHES-1:0] press_reg;
    logic [NUM_SWITCHES-1:0] release_reg;
    logic [NUM_SWITCHES-1:0] pressed_reg;
    logic [NUM_SWITCHES-1:0] closed_reg;

    assign in_ready = !valid_reg || out_ch.ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_SWITCHES; i++)
        begin
            press_next[i]   = results[i].press_event;
            release_next[i] = results[i].release_event;
            pressed_next[i] = results[i].pressed_now;
            closed_next[i]  = results[i].debounced_closed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            pressed_reg <= pressed_next;
            closed_reg  <= closed_next;
        end
    end

    assign out_ch.valid            = valid_reg;
    assign out_ch.press_events     = press_reg;
    assign out_ch.release_events   = release_reg;
    assign out_ch.pressed_now      = pressed_reg;
    assign out_ch.debounced_closed = closed_reg;

endmodule

>>> design/multi_switch_debounce_events.sv
// ----------------------------------------------------------------------------
// multi_switch_debounce_events
// Debounces a group of active-low switches against a scan time stamp and
// reports press and release events, one event word per scan word.
// ----------------------------------------------------------------------------
// Each scan word is accepted when valid and ready are both high, and its event
// word is captured in the output register at that clock edge; a new scan word
// can be taken every cycle unless the held event word is not yet taken.
// The output register lets a scan word in while the previous event word is
// being taken. The debounce time is written through cfg_we/cfg_wdata; zero is
// stored as one.
module multi_switch_debounce_events #(
    parameter int NUM_SWITCHES = mswdb_pkg::NUM_SWITCHES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mswdb_pkg::DEBOUNCE_W-1:0]    cfg_wdata,
    mswdb_scan_if.sink                          in_ch,
    mswdb_event_if.source                       out_ch
);

    logic [mswdb_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic                             in_ready;
    logic                             accept;
    mswdb_pkg::lane_result_t          results [NUM_SWITCHES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= mswdb_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= (cfg_wdata == '0) ? mswdb_pkg::DEBOUNCE_MIN : cfg_wdata;
        end
    end

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    for (genvar g = 0; g < NUM_SWITCHES; g++)
    begin : g_lane
        mswdb_lane u_lane
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .accept        (accept),
            .now_time      (in_ch.now_time),
            .raw_line      (in_ch.raw_lines[g]),
            .debounce_time (debounce_reg),
            .result        (results[g])
        );
    end

    mswdb_merge #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .results  (results),
        .out_ch   (out_ch)
    );

endmodule
